FILE: rtl/cpt_pkg.sv
package cpt_pkg;

	localparam int NUM_TIMERS = 4;
	localparam int IDX_W = $clog2(NUM_TIMERS);
	localparam int TICK_W = 11;

	localparam logic [1:0] BYTE_RELOAD_LO = 2'd0;
	localparam logic [1:0] BYTE_RELOAD_HI = 2'd1;
	localparam logic [1:0] BYTE_CONTROL = 2'd2;
	localparam logic [1:0] BYTE_UNUSED = 2'd3;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_ELAPSE = 1'b1;

	localparam int CTL_CASCADE_BIT = 2;
	localparam int CTL_IRQ_BIT = 6;
	localparam int CTL_ENABLE_BIT = 7;

	typedef struct packed {
		logic       command;
		logic [3:0] reg_offset;
		logic [7:0] write_byte;
		logic [7:0] elapsed_cycles;
	} cpt_in_t;

	typedef struct packed {
		logic [15:0] count_zero;
		logic [15:0] count_one;
		logic [15:0] count_two;
		logic [15:0] count_three;
		logic [7:0]  overflows_zero;
		logic [7:0]  overflows_one;
		logic [7:0]  overflows_two;
		logic [7:0]  overflows_three;
		logic [3:0]  irq_request_mask;
	} cpt_out_t;

	typedef struct packed {
		logic [15:0]       reload;
		logic [15:0]       counter;
		logic [TICK_W-1:0] remainder;
		logic [1:0]        sel;
		logic              cascade;
		logic              irq_en;
		logic              enable;
	} cpt_entry_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		cpt_entry_t       wr_data;
	} cpt_mem_req_t;

	function automatic logic [3:0] prescale_shift(input logic [1:0] sel);
		logic [3:0] sh;
		case (sel)
			2'd0: sh = 4'd0;
			2'd1: sh = 4'd6;
			2'd2: sh = 4'd8;
			2'd3: sh = 4'd10;
			default: sh = 4'd0;
		endcase
		return sh;
	endfunction

endpackage

FILE: rtl/cascading_prescaled_timers_top.sv
// Four 16-bit prescaled timers with cascade. Pulse start while busy is low to
// issue a register byte write or an elapse command; exactly one result follows,
// shown for a single cycle with result_valid, and it cannot be held off. Timer
// state lives in a small memory that is read, updated and written back one timer
// at a time, then read again to publish the four counters. During an elapse the
// overflow loop retires one reload per cycle.
module cascading_prescaled_timers_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cpt_pkg::cpt_in_t  item,
	output logic              busy,
	output logic              result_valid,
	output cpt_pkg::cpt_out_t result
);

	cpt_pkg::cpt_mem_req_t req;
	cpt_pkg::cpt_entry_t rdata;

	cpt_state_mem u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rdata (rdata)
	);

	cpt_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.item        (item),
		.busy        (busy),
		.result_valid(result_valid),
		.result      (result),
		.req         (req),
		.rdata       (rdata)
	);

endmodule

FILE: rtl/cpt_state_mem.sv
module cpt_state_mem (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cpt_pkg::cpt_mem_req_t req,
	output cpt_pkg::cpt_entry_t   rdata
);

	cpt_pkg::cpt_entry_t mem [cpt_pkg::NUM_TIMERS];
	logic [cpt_pkg::NUM_TIMERS-1:0] written_q;
	cpt_pkg::cpt_entry_t rd_s1;
	logic rd_valid_s1;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_s1 <= mem[req.rd_addr];
		end
	end

	// entries never written read as the reset value (all zero)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (req.wr_en) begin
				written_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_s1 <= written_q[req.rd_addr];
			end
		end
	end

	assign rdata = rd_valid_s1 ? rd_s1 : '0;

endmodule

FILE: rtl/cpt_engine.sv
module cpt_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  cpt_pkg::cpt_in_t      item,
	output logic                  busy,
	output logic                  result_valid,
	output cpt_pkg::cpt_out_t     result,
	output cpt_pkg::cpt_mem_req_t req,
	input  cpt_pkg::cpt_entry_t   rdata
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_LOAD = 7'b0000010,
		ST_ADV  = 7'b0000100,
		ST_WB   = 7'b0001000,
		ST_COLR = 7'b0010000,
		ST_COLC = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	localparam int IW = cpt_pkg::IDX_W;
	localparam int TW = cpt_pkg::TICK_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(cpt_pkg::NUM_TIMERS - 1);

	state_t state_q;
	cpt_pkg::cpt_in_t item_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] col_q;
	logic [TW-1:0] carry_q;
	logic [TW-1:0] n_q;
	logic [16:0] vsum_q;
	cpt_pkg::cpt_entry_t ent_q;
	logic [7:0] ovf_q [cpt_pkg::NUM_TIMERS];
	logic [15:0] cnt_q [cpt_pkg::NUM_TIMERS];
	logic [cpt_pkg::NUM_TIMERS-1:0] irq_q;

	logic [3:0] sh;
	logic [TW-1:0] psum;
	logic [TW-1:0] ticks;
	logic [TW-1:0] new_rem;
	cpt_pkg::cpt_entry_t adv_ent;
	cpt_pkg::cpt_entry_t wr_ent;
	logic [IW-1:0] wr_idx;

	assign wr_idx = item_q.reg_offset[3:2];

	// prescaler and register-write update on the entry just read
	always_comb begin
		sh = cpt_pkg::prescale_shift(rdata.sel);
		psum = rdata.remainder + TW'(item_q.elapsed_cycles);
		ticks = '0;
		new_rem = rdata.remainder;
		if (rdata.enable && !rdata.cascade) begin
			ticks = psum >> sh;
			new_rem = psum & ((TW'(1) << sh) - TW'(1));
		end else if (rdata.enable) begin
			ticks = carry_q;
		end

		adv_ent = rdata;
		adv_ent.remainder = new_rem;

		wr_ent = rdata;
		case (item_q.reg_offset[1:0])
			cpt_pkg::BYTE_RELOAD_LO: wr_ent.reload[7:0] = item_q.write_byte;
			cpt_pkg::BYTE_RELOAD_HI: wr_ent.reload[15:8] = item_q.write_byte;
			cpt_pkg::BYTE_CONTROL: begin
				wr_ent.sel = item_q.write_byte[1:0];
				wr_ent.cascade = (wr_idx != '0) &&
					item_q.write_byte[cpt_pkg::CTL_CASCADE_BIT];
				wr_ent.irq_en = item_q.write_byte[cpt_pkg::CTL_IRQ_BIT];
				wr_ent.enable = item_q.write_byte[cpt_pkg::CTL_ENABLE_BIT];
				if (!rdata.enable && item_q.write_byte[cpt_pkg::CTL_ENABLE_BIT]) begin
					wr_ent.counter = rdata.reload;
					wr_ent.remainder = '0;
				end
			end
			default: wr_ent = rdata;
		endcase
	end

	always_comb begin
		req = '0;
		req.wr_data = ent_q;
		case (state_q)
			ST_IDLE: begin
				req.rd_en = start;
				req.rd_addr = (item.command == cpt_pkg::CMD_WRITE) ? item.reg_offset[3:2] : '0;
			end
			ST_WB: begin
				req.wr_en = 1'b1;
				req.wr_addr = idx_q;
				req.rd_en = 1'b1;
				req.rd_addr = idx_q + IW'(1);
			end
			ST_COLR: begin
				req.rd_en = 1'b1;
				req.rd_addr = col_q;
			end
			default: req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			col_q <= '0;
			carry_q <= '0;
			n_q <= '0;
			irq_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						idx_q <= (item.command == cpt_pkg::CMD_WRITE) ? item.reg_offset[3:2] : '0;
						carry_q <= '0;
						irq_q <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					n_q <= '0;
					if (item_q.command == cpt_pkg::CMD_WRITE) begin
						state_q <= ST_WB;
					end else begin
						state_q <= ST_ADV;
					end
				end
				ST_ADV: begin
					// one overflow per cycle
					if (vsum_q[16]) begin
						n_q <= n_q + TW'(1);
					end else begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (item_q.command == cpt_pkg::CMD_ELAPSE) begin
						carry_q <= n_q;
						if (n_q != '0 && ent_q.irq_en) begin
							irq_q[idx_q] <= 1'b1;
						end
					end
					if (item_q.command == cpt_pkg::CMD_WRITE || idx_q == LAST_IDX) begin
						col_q <= '0;
						state_q <= ST_COLR;
					end else begin
						idx_q <= idx_q + IW'(1);
						state_q <= ST_LOAD;
					end
				end
				ST_COLR: state_q <= ST_COLC;
				ST_COLC: begin
					if (col_q == LAST_IDX) begin
						state_q <= ST_DONE;
					end else begin
						col_q <= col_q + IW'(1);
						state_q <= ST_COLR;
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			item_q <= item;
			for (int i = 0; i < cpt_pkg::NUM_TIMERS; i++) begin
				ovf_q[i] <= '0;
			end
		end
		if (state_q == ST_LOAD) begin
			if (item_q.command == cpt_pkg::CMD_WRITE) begin
				ent_q <= wr_ent;
			end else begin
				ent_q <= adv_ent;
				vsum_q <= {1'b0, rdata.counter} + 17'(ticks);
			end
		end
		if (state_q == ST_ADV) begin
			if (vsum_q[16]) begin
				vsum_q <= {1'b0, vsum_q[15:0]} + {1'b0, ent_q.reload};
			end else begin
				ent_q.counter <= vsum_q[15:0];
			end
		end
		if (state_q == ST_WB && item_q.command == cpt_pkg::CMD_ELAPSE) begin
			ovf_q[idx_q] <= (n_q > TW'(255)) ? 8'hFF : n_q[7:0];
		end
		if (state_q == ST_COLC) begin
			cnt_q[col_q] <= rdata.counter;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_DONE);

	always_comb begin
		result.count_zero = cnt_q[0];
		result.count_one = cnt_q[1];
		result.count_two = cnt_q[2];
		result.count_three = cnt_q[3];
		result.overflows_zero = ovf_q[0];
		result.overflows_one = ovf_q[1];
		result.overflows_two = ovf_q[2];
		result.overflows_three = ovf_q[3];
		result.irq_request_mask = irq_q;
	end

endmodule

FILE: rtl/cpt_checker.sv
module cpt_sva_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              result_valid,
	input cpt_pkg::cpt_out_t result
);

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result strobe longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted transaction did not raise busy");

	a_result_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result outside a transaction");

	a_free_after: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !busy) else $error("busy held after result");

	a_irq_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.irq_request_mask[0] |-> result.overflows_zero != 8'd0)
		else $error("interrupt without overflow");

endmodule

bind cascading_prescaled_timers_top cpt_sva_checker u_cpt_sva_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.result_valid(result_valid),
	.result      (result)
);
